### rtl/core/orq_pkg.sv
// Package for the overwriting ring queue: operation and status codes.
// Used by the top level and the assertion checker; depends on nothing.
package orq_pkg;

  typedef enum logic [2:0] {
    OP_ENQUEUE = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_PEEK    = 3'd2,
    OP_DROP    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned REC_IO_W = 32;
  localparam int unsigned OCC_W    = 7;

endpackage

### rtl/core/orq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the overwriting ring queue for its record store.
module orq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while the read enable is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/overwriting_ring_queue.sv
// Overwriting ring queue top level: pointers, occupancy and result register.
// Depends on orq_pkg and orq_ram.
//
// The queue keeps up to DEPTH records in a single RAM with a registered
// read and takes one operation per clock while the result side is ready:
// enqueue, dequeue, peek, drop newest or clear. Each accepted operation gives
// exactly one result beat, presented in the cycle after acceptance; with the
// result side ready it sustains one operation every cycle. Pointers and
// occupancy are settled in the cycle of acceptance, and the RAM write or read
// is issued in that same cycle, so the RAM's registered read sets the delay
// from input to result. A read always lands after any earlier write, so
// no forwarding is needed. The store is not cleared after reset
// and is ready at once; enqueue on a full queue replaces the oldest record
// and reports it in the overwrote flag.
module overwriting_ring_queue #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned RECORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_write_record,
  input  logic [15:0] in_peek_offset,
  input  logic [15:0] in_drop_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_record,
  output logic [6:0]  out_occupancy,
  output logic        out_overwrote
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  orq_pkg::status_t     status_r, status_nxt;
  logic [CW-1:0]        occ_r;
  logic                 over_r, over_nxt;
  logic                 use_rd_r, use_rd_nxt;

  logic                    accept;
  orq_pkg::op_t            op;
  logic                    ram_we, ram_re;
  logic [PW-1:0]           ram_raddr;
  logic [RECORD_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [63:0]             wr_ext, rd_ext;
  logic [PW:0]             peek_sum, drop_sum;
  logic [CW-1:0]           drop_n;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = orq_pkg::op_t'(in_operation);

  assign wr_ext    = 64'(in_write_record);
  assign ram_wdata = wr_ext[RECORD_WIDTH-1:0];
  assign rd_ext    = 64'(ram_rdata);

  // Peek address wraps once round the store; only used when offset < count.
  assign peek_sum = {1'b0, rd_ptr_r} + (PW + 1)'(in_peek_offset);
  assign drop_n   = (17'(in_drop_amount) < 17'(cnt_r)) ? CW'(in_drop_amount) : cnt_r;
  assign drop_sum = {1'b0, wr_ptr_r} + DEPTH_W - (PW + 1)'(drop_n);

  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    cnt_nxt       = cnt_r;
    status_nxt    = orq_pkg::ST_OK;
    over_nxt      = 1'b0;
    use_rd_nxt    = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = rd_ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      out_valid_nxt = 1'b1;
      case (op)
        orq_pkg::OP_ENQUEUE: begin
          ram_we     = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
          if (cnt_r == FULL_CNT) begin
            rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
            over_nxt   = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        orq_pkg::OP_DEQUEUE: begin
          if (cnt_r == '0) begin
            status_nxt = orq_pkg::ST_EMPTY;
          end else begin
            ram_re     = 1'b1;
            use_rd_nxt = 1'b1;
            rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
            cnt_nxt    = cnt_r - 1'b1;
          end
        end
        orq_pkg::OP_PEEK: begin
          if (cnt_r == '0) begin
            status_nxt = orq_pkg::ST_EMPTY;
          end else if (17'(in_peek_offset) >= 17'(cnt_r)) begin
            status_nxt = orq_pkg::ST_RANGE;
          end else begin
            ram_re     = 1'b1;
            use_rd_nxt = 1'b1;
            ram_raddr  = (peek_sum >= DEPTH_W) ? PW'(peek_sum - DEPTH_W) : PW'(peek_sum);
          end
        end
        orq_pkg::OP_DROP: begin
          wr_ptr_nxt = (drop_sum >= DEPTH_W) ? PW'(drop_sum - DEPTH_W) : PW'(drop_sum);
          cnt_nxt    = cnt_r - drop_n;
        end
        orq_pkg::OP_CLEAR: begin
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          cnt_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      occ_r    <= cnt_nxt;
      over_r   <= over_nxt;
      use_rd_r <= use_rd_nxt;
    end
  end

  orq_ram #(
    .WIDTH (RECORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_record = use_rd_r ? rd_ext[31:0] : 32'd0;
  assign out_occupancy   = 7'(occ_r);
  assign out_overwrote   = over_r;

endmodule

### rtl/core/orq_checker.sv
// Port-level assertions for the overwriting ring queue, bound to the top level.
// Depends on orq_pkg and on overwriting_ring_queue.
module orq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_read_record,
  input logic [6:0]  out_occupancy,
  input logic        out_overwrote
);

  // An error result never carries a record.
  a_err_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != orq_pkg::ST_OK) |-> out_read_record == 32'd0)
    else $error("error status with a non-zero record");

  // Overwriting happens only on a successful enqueue into a full queue.
  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overwrote |-> (out_status == orq_pkg::ST_OK) && (out_occupancy != 7'd0))
    else $error("overwrite flagged on an error or an empty queue");

  // A peek range error implies entries are stored.
  a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == orq_pkg::ST_RANGE) |-> out_occupancy != 7'd0)
    else $error("range error reported with an empty queue");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_read_record) && $stable(out_occupancy))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind overwriting_ring_queue orq_checker u_orq_checker (.*);
